### rtl/bmap_pkg.sv
// shared widths and operation codes for the bitmap allocator
`timescale 1ns / 1ps

package bmap_pkg;

    localparam int FUNC_W    = 2;
    localparam int INDEX_W   = 10;
    localparam int WORD_BITS = 32;
    localparam int POS_W     = 5;
    // a 10-bit index reaches at most this many words
    localparam int INDEX_WORDS = (1 << INDEX_W) / WORD_BITS;

    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    // position of the lowest clear bit; only meaningful when a clear bit exists
    function automatic logic [POS_W-1:0] lowest_zero(input t_word w);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                pos = POS_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

### rtl/bitmap_allocator.sv
// bitmap allocator: inode and data block maps in one word memory, set/toggle/find-first-free
//
//  channel   | handshake           | fields
//  ----------+---------------------+-----------------------------------------
//  request   | start, busy         | i_func, i_map_select, i_bit_index
//  result    | o_done (one cycle)  | o_free_index, o_map_full
//
//  set/toggle: read-modify-write of one word: read at the transfer, written in S_MODIFY, then o_done registered
//  find: one memory word per cycle, result at the first word with a clear bit or at the last of min(MAP_WORDS,32) words
//  unused code or a bit beyond the map: result in the cycle after the transfer
//  reset clears per-word valid bits at once, so the maps read as zero with no sweep
//  the receiver cannot stall; busy is low whenever a new request can be taken
`timescale 1ns / 1ps

module bitmap_allocator #(
    parameter int MAP_WORDS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bmap_pkg::FUNC_W-1:0]   i_func,
    input  logic                          i_map_select,
    input  logic [bmap_pkg::INDEX_W-1:0]  i_bit_index,
    output logic                          o_done,
    output logic [bmap_pkg::INDEX_W-1:0]  o_free_index,
    output logic                          o_map_full
);
    import bmap_pkg::*;

    // words beyond a 10-bit index can never be touched
    localparam int USED_WORDS = (MAP_WORDS < INDEX_WORDS) ? MAP_WORDS : INDEX_WORDS;
    localparam int WORD_W     = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
    localparam int ADDR_W     = WORD_W + 1;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(USED_WORDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN
    } t_state;

    t_word              mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_valid;
    t_word              r_rd_data;
    logic               r_rd_valid;

    t_state             r_state, n_state;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic               r_map, n_map;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_done, n_done;
    logic [INDEX_W-1:0] r_free, n_free;
    logic               r_full, n_full;

    logic [POS_W-1:0]   in_word;
    logic               in_range;
    t_word              cur_word;
    logic [POS_W-1:0]   zero_pos;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    t_word              wr_data;

    assign in_word  = i_bit_index[INDEX_W-1 -: POS_W];
    assign in_range = (32'(in_word) < 32'(MAP_WORDS));
    assign cur_word = r_rd_valid ? r_rd_data : '0;
    assign zero_pos = lowest_zero(cur_word);
    assign wr_addr  = {r_map, r_word};
    assign wr_data  = (r_func == FUNC_SET) ? (cur_word | (t_word'(1) << r_pos))
                                           : (cur_word ^ (t_word'(1) << r_pos));

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_free_index = r_free;
    assign o_map_full   = r_full;

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_map   = r_map;
        n_word  = r_word;
        n_pos   = r_pos;
        n_done  = 1'b0;
        n_free  = '0;
        n_full  = 1'b0;
        mem_we  = 1'b0;
        // while scanning, fetch the word after the one being examined
        rd_addr = {r_map, r_word + WORD_W'(1)};

        unique case (r_state)
            S_IDLE: begin
                rd_addr = {i_map_select, in_word[WORD_W-1:0]};
                if (start) begin
                    n_func = i_func;
                    n_map  = i_map_select;
                    n_word = in_word[WORD_W-1:0];
                    n_pos  = i_bit_index[POS_W-1:0];
                    if (i_func == FUNC_FIND) begin
                        rd_addr = {i_map_select, {WORD_W{1'b0}}};
                        n_word  = '0;
                        n_state = S_SCAN;
                    end else if ((i_func == FUNC_SET || i_func == FUNC_TOGGLE) && in_range) begin
                        n_state = S_MODIFY;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_MODIFY: begin
                mem_we  = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (cur_word != '1) begin
                    n_done  = 1'b1;
                    n_free  = INDEX_W'({r_word, zero_pos});
                    n_state = S_IDLE;
                end else if (r_word == LAST_WORD) begin
                    n_done  = 1'b1;
                    n_full  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + WORD_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_full  <= 1'b0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_full  <= n_full;
            r_free  <= n_free;
        end
        r_func <= n_func;
        r_map  <= n_map;
        r_word <= n_word;
        r_pos  <= n_pos;
    end

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request made no progress");

    a_full_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_map_full) |-> (o_free_index == '0))
        else $error("full map reported a nonzero index");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("memory write during a find scan");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_word <= LAST_WORD))
        else $error("scan ran past the last map word");

    a_modify_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MODIFY) |=> (o_done && !o_map_full && r_state == S_IDLE))
        else $error("read-modify-write did not complete in one cycle");

endmodule
